@@ sv/wwtc_pkg.sv @@
// Package for the word wrap text console unit.
// Holds the result record, field widths, character codes and register indexes.
// Used by the top level, the step unit and the output stage; depends on nothing.
package wwtc_pkg;

    localparam int CH_W       = 8;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 6;
    localparam int GLYPH_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 2;

    localparam logic [CH_W-1:0] CH_NL       = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CH_W-1:0] CH_COLOUR_A = 8'h01;
    localparam logic [CH_W-1:0] CH_COLOUR_B = 8'h02;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OR_MASK     = 2'd2;

    localparam int LW_RESET = 38;
    localparam int TL_RESET = 1024;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GLYPH_W-1:0] glyph;
        logic               wr;
        logic               clr;
    } t_result;

endpackage

@@ sv/word_wrap_text_console_unit.sv @@
// Top level of the word wrap text console unit: sequencer, word buffer and config.
// Depends on wwtc_pkg, wwtc_ram, wwtc_step and wwtc_out.
//
// Channel  Dir  Handshake                  Payload
// s        in   i_s_tvalid / o_s_tready    tdata ch, tuser msg_start, tlast msg_end
// m        out  o_m_tvalid / i_m_tready    tdata row,col,glyph; tuser wr,clr; tlast
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A direct byte passes states start, main, byte and drain; a buffered byte skips byte,
// a colour selector passes start, hdr and drain, and any other message start adds hdr.
// A word flush adds fl_addr, then steps one buffered byte a cycle unless the output stalls.
// The input is ready only while the sequencer is idle.
// Reset is synchronous; the word buffer needs no clearing.
// A stalled output holds the sequencer in its current step.
module word_wrap_text_console_unit #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_LINES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wwtc_pkg::IN_DATA_W-1:0]  i_s_tdata,  // ch
    input  logic                            i_s_tuser,  // msg_start
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wwtc_pkg::OUT_DATA_W-1:0] o_m_tdata,  // row, col, glyph, zero pad
    output logic [wwtc_pkg::OUT_USER_W-1:0] o_m_tuser,  // write_glyph, clear_row
    output logic                            o_m_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wwtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wwtc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wwtc_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH+1);
    localparam int RW    = $clog2(MAX_LINES);
    localparam int TW    = $clog2(MAX_LINES+1);
    localparam int W_RST = (LW_RESET > MAX_WIDTH) ? MAX_WIDTH : LW_RESET;
    localparam int T_RST = (TL_RESET > MAX_LINES) ? MAX_LINES : TL_RESET;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START   = 3'd1;
    localparam logic [2:0] S_HDR     = 3'd2;
    localparam logic [2:0] S_MAIN    = 3'd3;
    localparam logic [2:0] S_FL_ADDR = 3'd4;
    localparam logic [2:0] S_FL_RUN  = 3'd5;
    localparam logic [2:0] S_BYTE    = 3'd6;
    localparam logic [2:0] S_DRAIN   = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_ret, n_ret;
    logic [CH_W-1:0]    r_ch, n_ch;
    logic               r_start, n_start;
    logic               r_end, n_end;
    logic [AW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic               r_pend, n_pend;
    logic               r_atwb, n_atwb;
    logic               r_colour, n_colour;
    logic [WW-1:0]      r_count, n_count;
    logic [WW-1:0]      r_fidx, n_fidx;
    logic [WW-1:0]      r_w, n_w;
    logic [TW-1:0]      r_t, n_t;
    logic [GLYPH_W-1:0] r_or, n_or;

    logic               s_acc;
    logic               cfg_acc;
    logic               wordch;
    logic [WW-1:0]      count_inc;
    logic [6:0]         cfg_lw;
    logic [10:0]        cfg_tl;
    logic [WW-1:0]      eff_w;
    logic [TW-1:0]      eff_t;

    logic               ram_we;
    logic [AW-1:0]      ram_wa;
    logic               ram_re;
    logic [AW-1:0]      ram_ra;
    logic [CH_W-1:0]    ram_rd;

    logic [CH_W-1:0]    st_ch;
    logic [AW-1:0]      st_col;
    logic [RW-1:0]      st_row;
    logic               st_pend;
    logic               st_emit;
    t_result            st_res;

    logic               push;
    logic               fin;
    logic               stage_ok;

    wwtc_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_WIDTH)
    ) u_word (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (r_ch),
        .i_re    (ram_re),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign st_ch = (r_state == S_FL_RUN) ? ram_rd : r_ch;

    wwtc_step #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) u_step (
        .i_col      (r_col),
        .i_row      (r_row),
        .i_ret_pend (r_pend),
        .i_ch       (st_ch),
        .i_colour   (r_colour),
        .i_or_mask  (r_or),
        .i_width    (r_w),
        .i_lines    (r_t),
        .o_col      (st_col),
        .o_row      (st_row),
        .o_ret_pend (st_pend),
        .o_emit     (st_emit),
        .o_res      (st_res)
    );

    wwtc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (st_res),
        .i_fin      (fin),
        .o_stage_ok (stage_ok),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign wordch      = (r_ch > CH_SPACE) && !r_ch[CH_W-1];
    assign count_inc   = r_count + WW'(1);
    assign cfg_lw      = i_cfg_data[6:0];
    assign cfg_tl      = i_cfg_data[10:0];

    always_comb begin
        if (cfg_lw == '0) begin
            eff_w = WW'(1);
        end else if (32'(cfg_lw) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_lw);
        end
        if (cfg_tl == '0) begin
            eff_t = TW'(1);
        end else if (32'(cfg_tl) > MAX_LINES) begin
            eff_t = TW'(MAX_LINES);
        end else begin
            eff_t = TW'(cfg_tl);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_ch     = r_ch;
        n_start  = r_start;
        n_end    = r_end;
        n_col    = r_col;
        n_row    = r_row;
        n_pend   = r_pend;
        n_atwb   = r_atwb;
        n_colour = r_colour;
        n_count  = r_count;
        n_fidx   = r_fidx;
        n_w      = r_w;
        n_t      = r_t;
        n_or     = r_or;
        ram_we   = 1'b0;
        ram_wa   = '0;
        ram_re   = 1'b0;
        ram_ra   = '0;
        push     = 1'b0;
        fin      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_ch    = i_s_tdata[CH_W-1:0];
                    n_start = i_s_tuser;
                    n_end   = i_s_tlast;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_start && r_count != '0) begin
                    n_ret   = S_HDR;
                    n_state = S_FL_ADDR;
                end else if (r_start) begin
                    n_state = S_HDR;
                end else begin
                    n_state = S_MAIN;
                end
            end
            S_HDR: begin
                n_atwb = 1'b1;
                if (r_ch == CH_COLOUR_A || r_ch == CH_COLOUR_B) begin
                    n_colour = 1'b1;
                    n_state  = S_DRAIN;
                end else begin
                    n_colour = 1'b0;
                    n_state  = S_MAIN;
                end
            end
            S_MAIN: begin
                if (r_count != '0) begin
                    if (wordch) begin
                        ram_we  = 1'b1;
                        ram_wa  = r_count[AW-1:0];
                        n_count = count_inc;
                        if (count_inc >= r_w || r_end) begin
                            n_ret   = S_DRAIN;
                            n_state = S_FL_ADDR;
                        end else begin
                            n_state = S_DRAIN;
                        end
                    end else begin
                        if (r_ch <= CH_SPACE) begin
                            n_atwb = 1'b1;
                        end
                        n_ret   = S_BYTE;
                        n_state = S_FL_ADDR;
                    end
                end else if (r_ch <= CH_SPACE) begin
                    n_atwb  = 1'b1;
                    n_state = S_BYTE;
                end else if (!wordch) begin
                    n_atwb  = 1'b0;
                    n_state = S_BYTE;
                end else if (r_atwb) begin
                    n_atwb  = 1'b0;
                    ram_we  = 1'b1;
                    ram_wa  = '0;
                    n_count = WW'(1);
                    if (r_w == WW'(1) || r_end) begin
                        n_ret   = S_DRAIN;
                        n_state = S_FL_ADDR;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_state = S_BYTE;
                end
            end
            S_FL_ADDR: begin
                if (r_count != r_w &&
                    (WW+1)'(r_col) + (WW+1)'(r_count) > (WW+1)'(r_w)) begin
                    n_col = '0;
                end
                ram_re  = 1'b1;
                ram_ra  = '0;
                n_fidx  = WW'(1);
                n_state = S_FL_RUN;
            end
            S_FL_RUN: begin
                if (stage_ok) begin
                    n_col  = st_col;
                    n_row  = st_row;
                    n_pend = st_pend;
                    push   = st_emit;
                    if (r_fidx == r_count) begin
                        n_count = '0;
                        n_state = r_ret;
                    end else begin
                        ram_re = 1'b1;
                        ram_ra = r_fidx[AW-1:0];
                        n_fidx = r_fidx + WW'(1);
                    end
                end
            end
            S_BYTE: begin
                if (stage_ok) begin
                    n_col   = st_col;
                    n_row   = st_row;
                    n_pend  = st_pend;
                    push    = st_emit;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                fin = 1'b1;
                if (stage_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH: begin
                    n_w     = eff_w;
                    n_col   = '0;
                    n_row   = RW'(r_t - TW'(1));
                    n_pend  = 1'b0;
                    n_count = '0;
                end
                CFG_TOTAL_LINES: begin
                    n_t   = eff_t;
                    n_row = RW'(eff_t - TW'(1));
                end
                CFG_OR_MASK: begin
                    n_or = i_cfg_data[GLYPH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_DRAIN;
            r_col    <= '0;
            r_row    <= RW'(T_RST - 1);
            r_pend   <= 1'b0;
            r_atwb   <= 1'b1;
            r_colour <= 1'b0;
            r_count  <= '0;
            r_fidx   <= '0;
            r_w      <= WW'(W_RST);
            r_t      <= TW'(T_RST);
            r_or     <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pend   <= n_pend;
            r_atwb   <= n_atwb;
            r_colour <= n_colour;
            r_count  <= n_count;
            r_fidx   <= n_fidx;
            r_w      <= n_w;
            r_t      <= n_t;
            r_or     <= n_or;
        end
        r_ch    <= n_ch;
        r_start <= n_start;
        r_end   <= n_end;
    end

endmodule

@@ sv/wwtc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// Holds the buffered word of the console unit; depends on nothing.
module wwtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wwtc_step.sv @@
// Shared character step unit: moves the cursor for one byte and forms its result.
// Used for buffered and direct bytes alike; colour selectors skip it. Depends on wwtc_pkg.
module wwtc_step #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_LINES = 1024
) (
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_col,
    input  logic [$clog2(MAX_LINES)-1:0]   i_row,
    input  logic                           i_ret_pend,
    input  logic [wwtc_pkg::CH_W-1:0]      i_ch,
    input  logic                           i_colour,
    input  logic [wwtc_pkg::GLYPH_W-1:0]   i_or_mask,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_width,
    input  logic [$clog2(MAX_LINES+1)-1:0] i_lines,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_col,
    output logic [$clog2(MAX_LINES)-1:0]   o_row,
    output logic                           o_ret_pend,
    output logic                           o_emit,
    output wwtc_pkg::t_result              o_res
);
    import wwtc_pkg::*;

    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH+1);
    localparam int RW  = $clog2(MAX_LINES);
    localparam int TW  = $clog2(MAX_LINES+1);

    logic [RW-1:0]  row_a;
    logic [RW-1:0]  row_b;
    logic [TW-1:0]  row_inc;
    logic [WW-1:0]  col_inc;
    logic           clr;
    logic           wr;
    logic [CLW-1:0] col_w;

    always_comb begin
        if (i_ret_pend && (i_row == '0 || TW'(i_row) >= i_lines)) begin
            row_a = RW'(i_lines - TW'(1));
        end else if (i_ret_pend) begin
            row_a = i_row - RW'(1);
        end else begin
            row_a = i_row;
        end

        row_inc = TW'(row_a) + TW'(1);
        clr     = (i_col == '0);
        if (clr) begin
            row_b = (row_inc >= i_lines) ? '0 : RW'(row_inc);
        end else begin
            row_b = row_a;
        end

        col_inc    = WW'(i_col) + WW'(1);
        wr         = 1'b0;
        col_w      = '0;
        o_ret_pend = 1'b0;
        if (i_ch == CH_NL) begin
            o_col = '0;
        end else if (i_ch == CH_CR) begin
            o_col      = '0;
            o_ret_pend = 1'b1;
        end else begin
            wr    = 1'b1;
            col_w = i_col;
            o_col = (col_inc >= i_width) ? '0 : CLW'(col_inc);
        end

        o_row       = row_b;
        o_emit      = clr || wr;
        o_res.row   = ROW_W'(row_b);
        o_res.col   = wr ? COL_W'(col_w) : '0;
        o_res.glyph = wr ? ({1'b0, i_ch} | {i_colour, 8'h00} | i_or_mask) : '0;
        o_res.wr    = wr;
        o_res.clr   = clr;
    end

endmodule

@@ sv/wwtc_out.sv @@
// Output stage: one held result and the output register, so the final result of
// an item can be marked with tlast. Depends on wwtc_pkg.
module wwtc_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  wwtc_pkg::t_result               i_res,
    input  logic                            i_fin,
    output logic                            o_stage_ok,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wwtc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [wwtc_pkg::OUT_USER_W-1:0] o_m_tuser,
    output logic                            o_m_tlast
);
    import wwtc_pkg::*;

    logic    r_out_v, n_out_v;
    logic    r_pend_v, n_pend_v;
    logic    r_last, n_last;
    t_result r_out, n_out;
    t_result r_pend, n_pend;
    logic    out_free;

    always_comb begin
        out_free   = !r_out_v || i_m_tready;
        o_stage_ok = !r_pend_v || out_free;
        n_out_v    = r_out_v && !i_m_tready;
        n_out      = r_out;
        n_last     = r_last;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        if (i_push && o_stage_ok) begin
            if (r_pend_v) begin
                n_out   = r_pend;
                n_last  = 1'b0;
                n_out_v = 1'b1;
            end
            n_pend   = i_res;
            n_pend_v = 1'b1;
        end else if (i_fin && r_pend_v && out_free) begin
            n_out    = r_pend;
            n_last   = 1'b1;
            n_out_v  = 1'b1;
            n_pend_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
        r_out  <= n_out;
        r_last <= n_last;
        r_pend <= n_pend;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_DATA_W'({r_out.glyph, r_out.col, r_out.row});
    assign o_m_tuser  = {r_out.clr, r_out.wr};
    assign o_m_tlast  = r_last;

endmodule

@@ sim/word_wrap_text_console_unit_tb.sv @@
// Self-checking testbench for word_wrap_text_console_unit: a directed run, then random text.
// A scoreboard class predicts every console write from the accepted bytes and register writes.
// Depends on wwtc_pkg and the RTL of the unit only.
module word_wrap_text_console_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wwtc_pkg::*;

    localparam int MAX_W        = 64;
    localparam int MAX_L        = 1024;
    localparam int MAX_RESULTS  = 64;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 3000;
    localparam int REPORT_CAP   = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [CH_W-1:0]      CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0]      CH_HIGH   = 8'h80;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GLYPH_W-1:0] glyph;
        logic               wr;
        logic               clr;
        logic               last;
    } t_console_write;

    class console_scoreboard;
        t_console_write exp_q[$];
        int unsigned    errors;
        logic [6:0]     width_reg;
        logic [10:0]    lines_reg;
        logic [8:0]     mask_reg;
        int unsigned    cur_col;
        int unsigned    cur_row;
        int unsigned    word_len;
        int unsigned    step_results;
        bit             return_due;
        bit             word_start;
        bit             colour_on;
        logic [7:0]     word_buf [MAX_W];

        function new();
            errors     = 0;
            width_reg  = 7'(LW_RESET);
            lines_reg  = 11'(TL_RESET);
            mask_reg   = '0;
            cur_col    = 0;
            cur_row    = lines_now() - 1;
            return_due = 1'b0;
            word_start = 1'b1;
            colour_on  = 1'b0;
            word_len   = 0;
        endfunction

        function int unsigned width_now();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned lines_now();
            if (lines_reg == 0) return 1;
            if (lines_reg > MAX_L) return MAX_L;
            return lines_reg;
        endfunction

        function void step_byte(logic [7:0] c);
            int unsigned    w;
            int unsigned    t;
            int unsigned    col;
            bit             clr;
            bit             wr;
            t_console_write e;
            w   = width_now();
            t   = lines_now();
            col = 0;
            clr = 1'b0;
            wr  = 1'b0;
            if (return_due) begin
                cur_row    = (cur_row == 0 || cur_row >= t) ? t - 1 : cur_row - 1;
                return_due = 1'b0;
            end
            if (cur_col == 0) begin
                cur_row = (cur_row + 1 >= t) ? 0 : cur_row + 1;
                clr     = 1'b1;
            end
            if (c == CH_NL) begin
                cur_col = 0;
            end else if (c == CH_CR) begin
                cur_col    = 0;
                return_due = 1'b1;
            end else begin
                wr  = 1'b1;
                col = cur_col;
                cur_col++;
                if (cur_col >= w) cur_col = 0;
            end
            if ((clr || wr) && step_results < MAX_RESULTS) begin
                e.row   = ROW_W'(cur_row);
                e.col   = wr ? COL_W'(col) : '0;
                e.glyph = wr ? ({colour_on, c} | mask_reg) : '0;
                e.wr    = wr;
                e.clr   = clr;
                e.last  = 1'b0;
                exp_q.push_back(e);
                step_results++;
            end
        endfunction

        function void drain_word(int unsigned len);
            int unsigned w;
            int unsigned n;
            w = width_now();
            n = word_len;
            if (len != w && cur_col + len > w) cur_col = 0;
            word_len = 0;
            for (int unsigned i = 0; i < n && i < MAX_W; i++) step_byte(word_buf[i]);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LINE_WIDTH: begin
                    width_reg  = data[6:0];
                    cur_col    = 0;
                    cur_row    = lines_now() - 1;
                    return_due = 1'b0;
                    word_len   = 0;
                end
                CFG_TOTAL_LINES: begin
                    lines_reg = data;
                    cur_row   = lines_now() - 1;
                end
                CFG_OR_MASK: begin
                    mask_reg = data[8:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_input(logic [7:0] c, bit start, bit fin);
            int unsigned    w;
            bit             is_word;
            t_console_write e;
            w            = width_now();
            is_word      = (c > CH_SPACE) && (c < CH_HIGH);
            step_results = 0;
            if (start && word_len > 0) drain_word(word_len);
            if (start) word_start = 1'b1;
            if (start && (c == CH_COLOUR_A || c == CH_COLOUR_B)) begin
                colour_on = 1'b1;
            end else begin
                if (start) colour_on = 1'b0;
                if (word_len > 0) begin
                    if (is_word) begin
                        if (word_len < MAX_W) word_buf[word_len] = c;
                        word_len++;
                        if (word_len >= w) drain_word(w);
                        else if (fin) drain_word(word_len);
                    end else begin
                        drain_word(word_len);
                        if (c <= CH_SPACE) word_start = 1'b1;
                        step_byte(c);
                    end
                end else if (c <= CH_SPACE) begin
                    word_start = 1'b1;
                    step_byte(c);
                end else if (!is_word) begin
                    word_start = 1'b0;
                    step_byte(c);
                end else if (word_start) begin
                    word_start  = 1'b0;
                    word_buf[0] = c;
                    word_len    = 1;
                    if (word_len >= w) drain_word(w);
                    else if (fin) drain_word(1);
                end else begin
                    step_byte(c);
                end
            end
            if (step_results > 0) begin
                e      = exp_q.pop_back();
                e.last = 1'b1;
                exp_q.push_back(e);
            end
        endfunction

        task report(string msg);
            if (errors < REPORT_CAP) $display("%0t MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_console_write got);
            t_console_write want;
            if (exp_q.size() == 0) begin
                report($sformatf("unexpected write row %0d col %0d glyph %03h wr %0b clr %0b",
                                 got.row, got.col, got.glyph, got.wr, got.clr));
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    report($sformatf({"row %0d col %0d glyph %03h wr %0b clr %0b last %0b, ",
                                      "expected row %0d col %0d glyph %03h wr %0b clr %0b last %0b"},
                                     got.row, got.col, got.glyph, got.wr, got.clr, got.last,
                                     want.row, want.col, want.glyph, want.wr, want.clr,
                                     want.last));
                end
            end
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  i_s_tlast   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [OUT_USER_W-1:0] o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    console_scoreboard sb = new();
    t_console_write    seen;
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    int                items_sent     = 0;
    int                word_max       = 4;
    int                quiet_cycles   = 0;

    word_wrap_text_console_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.row   = o_m_tdata[9:0];
            seen.col   = o_m_tdata[15:10];
            seen.glyph = o_m_tdata[24:16];
            seen.wr    = o_m_tuser[0];
            seen.clr   = o_m_tuser[1];
            seen.last  = o_m_tlast;
            sb.check_result(seen);
        end
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic put_item(input logic [7:0] ch, input bit start, input bit fin);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= start;
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(ch, start, fin);
        items_sent++;
    endtask

    task automatic send_str(input string s, input bit start, input bit fin);
        for (int i = 0; i < s.len(); i++) begin
            put_item(s[i], start && i == 0, fin && i == s.len() - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, data);
    endtask

    task automatic program_console(input logic [10:0] lw, input logic [10:0] tl,
                                   input logic [10:0] om, input bit touch_spare);
        write_reg(CFG_LINE_WIDTH, lw);
        write_reg(CFG_TOTAL_LINES, tl);
        write_reg(CFG_OR_MASK, om);
        if (touch_spare) write_reg(CFG_SPARE, 11'h5A5);
        i_cfg_valid <= 1'b0;
    endtask

    // The unit can still be flushing a word after the last write it owes us.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_traffic(input int n_items);
        logic [7:0] msg[$];
        logic [7:0] sep;
        int         target;
        int         len;
        bit         fin;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(99) < 85) begin
                msg.delete();
                if ($urandom_range(3) == 0) begin
                    msg.push_back($urandom_range(1) ? CH_COLOUR_A : CH_COLOUR_B);
                end
                repeat ($urandom_range(1, 5)) begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(1, word_max + 2)
                                                   : $urandom_range(1, 6);
                    repeat (len) msg.push_back(8'($urandom_range(33, 127)));
                    if ($urandom_range(4) != 0) begin
                        case ($urandom_range(5))
                            0, 1, 2: sep = CH_SPACE;
                            3:       sep = $urandom_range(1) ? CH_NL : CH_CR;
                            4:       sep = 8'($urandom_range(31));
                            default: sep = 8'($urandom_range(128, 255));
                        endcase
                        msg.push_back(sep);
                    end
                end
                fin = ($urandom_range(4) != 0);
                foreach (msg[i]) put_item(msg[i], i == 0, fin && i == msg.size() - 1);
            end else begin
                put_item(8'($urandom_range(255)), $urandom_range(9) == 0,
                         $urandom_range(9) == 0);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Narrow lines and a three line ring make wraps and ring turnover show up early.
        program_console(11'd4, 11'd3, 11'd0, 1'b0);
        put_item(CH_COLOUR_A, 1'b1, 1'b0);
        send_str("ab ", 1'b0, 1'b0);
        send_str("abc", 1'b0, 1'b1);
        send_str("ABCDEF", 1'b1, 1'b0);
        put_item(CH_NL, 1'b0, 1'b0);
        put_item(CH_CR, 1'b0, 1'b0);
        put_item("x", 1'b0, 1'b0);
        put_item(8'hC8, 1'b0, 1'b0);
        put_item(8'h00, 1'b0, 1'b0);
        put_item(CH_TAB, 1'b0, 1'b0);
        put_item("w", 1'b0, 1'b0);
        put_item("o", 1'b0, 1'b0);
        put_item("Z", 1'b1, 1'b0);
        put_item("q", 1'b0, 1'b1);
        put_item("r", 1'b0, 1'b0);
        put_item(CH_COLOUR_B, 1'b1, 1'b0);
        put_item(8'hFF, 1'b0, 1'b1);
        settle();

        program_console(11'd64, 11'd1, 11'h7FF, 1'b0);
        word_max = 64;
        run_traffic(60);
        settle();

        program_console(11'd0, 11'd2047, 11'h0A5, 1'b0);
        word_max       = 1;
        src_idle_pct   = 63;
        run_traffic(60);
        settle();

        program_console(11'd13, 11'd0, 11'd0, 1'b1);
        word_max       = 13;
        src_idle_pct   = 0;
        sink_stall_pct = 63;
        run_traffic(60);
        settle();

        program_console(11'h7E4, 11'd1024, 11'h100, 1'b0);
        word_max       = 64;
        src_idle_pct   = 29;
        sink_stall_pct = 29;
        run_traffic(60);
        settle();

        if (sb.exp_q.size() != 0) begin
            sb.report($sformatf("%0d expected writes never arrived", sb.exp_q.size()));
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
